/* sv/dirc_pkg.sv */
// types and constants shared by the decimal integer range checker
`timescale 1ns / 1ps

package dirc_pkg;

   typedef enum logic [1:0] {
      STATUS_VALID        = 2'd0,
      STATUS_BAD_FORMAT   = 2'd1,
      STATUS_OUT_OF_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_S32 = 2'd0,
      KIND_S64 = 2'd1,
      KIND_U32 = 2'd2
   } kind_type;

   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned ACC_W    = 64;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned CSR_AW   = 3;
   localparam int unsigned CSR_DW   = 32;

   localparam logic [CSR_AW-1:0] CSR_ADDR_KIND = 3'd0;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2b;

   localparam logic [ACC_W-1:0] MAX_S32 = 64'h0000_0000_7fff_ffff;
   localparam logic [ACC_W-1:0] MAX_S64 = 64'h7fff_ffff_ffff_ffff;
   localparam logic [ACC_W-1:0] MAX_U32 = 64'h0000_0000_ffff_ffff;

   localparam logic [ACC_W-1:0] MAX_DIV10_S32 = MAX_S32 / 64'd10;
   localparam logic [ACC_W-1:0] MAX_DIV10_S64 = MAX_S64 / 64'd10;
   localparam logic [ACC_W-1:0] MAX_DIV10_U32 = MAX_U32 / 64'd10;

endpackage

/* sv/dirc_if.sv */
// valid/ready channel interfaces for character items and status items
`timescale 1ns / 1ps

interface dirc_req_if;
   logic                         valid;
   logic                         ready;
   logic [dirc_pkg::CHAR_W-1:0]  char_code;
   logic                         is_last;
   logic                         is_empty;

   modport source (output valid, output char_code, output is_last, output is_empty,
                   input ready);
   modport sink   (input valid, input char_code, input is_last, input is_empty,
                   output ready);
endinterface

interface dirc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [dirc_pkg::STATUS_W-1:0]  status;

   modport source (output valid, output status, input ready);
   modport sink   (input valid, input status, output ready);
endinterface

/* sv/decimal_integer_range_checker.sv */
// decimal integer range checker top level
// a final item is held in the input register, then its result in the result register
// throughput: one item per cycle, set by the single accumulate and compare stage; but
// a final item waits in the input register while the result register is full and not taken
// reset is synchronous and active high: clears the string state, empties both registers,
// and selects signed 32-bit
`timescale 1ns / 1ps

module decimal_integer_range_checker (
   input  logic                         clock,
   input  logic                         reset,
   dirc_req_if.sink                     req_chan,
   dirc_rsp_if.source                   rsp_chan,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [dirc_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [dirc_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [dirc_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready
);

   logic                          s1_vld_ff, s1_vld_in;
   logic [dirc_pkg::CHAR_W-1:0]   s1_char_ff;
   logic                          s1_last_ff;
   logic                          s1_empty_ff;
   logic                          s1_adv;

   logic [dirc_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic                          neg_ff, neg_in;
   logic                          first_ff, first_in;
   logic                          seen_ff, seen_in;
   dirc_pkg::status_type          err_ff, err_in;
   logic [dirc_pkg::KIND_W-1:0]   kind_ff, kind_in;

   logic                          rsp_vld_ff, rsp_vld_in;
   dirc_pkg::status_type          rsp_status_ff, rsp_status_in;

   logic                          is_signed;
   logic [dirc_pkg::ACC_W-1:0]    max_val;
   logic [dirc_pkg::ACC_W-1:0]    max_div10;
   logic [dirc_pkg::ACC_W-1:0]    limit;
   logic [dirc_pkg::ACC_W-1:0]    acc_x10;
   logic [dirc_pkg::ACC_W-1:0]    acc_sum;
   logic [dirc_pkg::CHAR_W-1:0]   digit;
   logic                          is_digit;
   logic                          is_sign;
   logic                          csr_wr;

   logic [dirc_pkg::ACC_W-1:0]    c_acc;
   logic                          c_neg;
   logic                          c_first;
   logic                          c_seen;
   dirc_pkg::status_type          c_err;
   dirc_pkg::status_type          c_status;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready
                       & (csr_paddr[dirc_pkg::CSR_AW-1] == 1'b0);
   assign kind_in    = csr_wr ? csr_pwdata[dirc_pkg::KIND_W-1:0] : kind_ff;

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[dirc_pkg::CSR_AW-1] == 1'b0) begin
         csr_prdata[dirc_pkg::KIND_W-1:0] = kind_ff;
      end
   end

   // handshake
   assign s1_adv         = s1_vld_ff & (~s1_last_ff | ~rsp_vld_ff | rsp_chan.ready);
   assign req_chan.ready = ~s1_vld_ff | s1_adv;
   assign s1_vld_in      = req_chan.ready ? req_chan.valid : s1_vld_ff;

   assign rsp_chan.valid  = rsp_vld_ff;
   assign rsp_chan.status = rsp_status_ff;

   // type limits
   always_comb begin
      case (kind_ff)
         dirc_pkg::KIND_S64: begin
            max_val   = dirc_pkg::MAX_S64;
            max_div10 = dirc_pkg::MAX_DIV10_S64;
         end
         dirc_pkg::KIND_U32: begin
            max_val   = dirc_pkg::MAX_U32;
            max_div10 = dirc_pkg::MAX_DIV10_U32;
         end
         default: begin
            max_val   = dirc_pkg::MAX_S32;
            max_div10 = dirc_pkg::MAX_DIV10_S32;
         end
      endcase
   end

   assign is_signed = (kind_ff != dirc_pkg::KIND_U32);
   assign limit     = max_val + {{(dirc_pkg::ACC_W-1){1'b0}}, is_signed & neg_ff};
   assign digit     = s1_char_ff - dirc_pkg::CHAR_ZERO;
   assign acc_x10   = {acc_ff[dirc_pkg::ACC_W-4:0], 3'b000}
                      + {acc_ff[dirc_pkg::ACC_W-2:0], 1'b0};
   assign acc_sum   = acc_x10 + {{(dirc_pkg::ACC_W-dirc_pkg::CHAR_W){1'b0}}, digit};
   assign is_digit  = (s1_char_ff >= dirc_pkg::CHAR_ZERO) && (s1_char_ff <= dirc_pkg::CHAR_NINE);
   assign is_sign   = (s1_char_ff == dirc_pkg::CHAR_MINUS) || (s1_char_ff == dirc_pkg::CHAR_PLUS);

   // one character step
   always_comb begin
      c_acc   = acc_ff;
      c_neg   = neg_ff;
      c_first = first_ff;
      c_seen  = seen_ff;
      c_err   = err_ff;
      if (!s1_empty_ff) begin
         c_first = 1'b0;
         if (err_ff != dirc_pkg::STATUS_VALID) begin
            c_err = err_ff;
         end else if (first_ff && is_signed && is_sign) begin
            c_neg = (s1_char_ff == dirc_pkg::CHAR_MINUS);
         end else if (!is_digit) begin
            c_err = dirc_pkg::STATUS_BAD_FORMAT;
         end else if ((acc_ff > max_div10) || (acc_sum > limit)) begin
            c_err = dirc_pkg::STATUS_OUT_OF_RANGE;
         end else begin
            c_acc  = acc_sum;
            c_seen = 1'b1;
         end
      end
   end

   always_comb begin
      if (c_err != dirc_pkg::STATUS_VALID) begin
         c_status = c_err;
      end else if (!c_seen) begin
         c_status = dirc_pkg::STATUS_BAD_FORMAT;
      end else begin
         c_status = dirc_pkg::STATUS_VALID;
      end
   end

   always_comb begin
      acc_in        = acc_ff;
      neg_in        = neg_ff;
      first_in      = first_ff;
      seen_in       = seen_ff;
      err_in        = err_ff;
      rsp_status_in = rsp_status_ff;
      rsp_vld_in    = rsp_vld_ff & ~rsp_chan.ready;
      if (s1_adv) begin
         if (s1_last_ff) begin
            acc_in        = '0;
            neg_in        = 1'b0;
            first_in      = 1'b1;
            seen_in       = 1'b0;
            err_in        = dirc_pkg::STATUS_VALID;
            rsp_status_in = c_status;
            rsp_vld_in    = 1'b1;
         end else begin
            acc_in   = c_acc;
            neg_in   = c_neg;
            first_in = c_first;
            seen_in  = c_seen;
            err_in   = c_err;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         acc_ff     <= '0;
         neg_ff     <= 1'b0;
         first_ff   <= 1'b1;
         seen_ff    <= 1'b0;
         err_ff     <= dirc_pkg::STATUS_VALID;
         kind_ff    <= dirc_pkg::KIND_S32;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         acc_ff     <= acc_in;
         neg_ff     <= neg_in;
         first_ff   <= first_in;
         seen_ff    <= seen_in;
         err_ff     <= err_in;
         kind_ff    <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         s1_char_ff  <= req_chan.char_code;
         s1_last_ff  <= req_chan.is_last;
         s1_empty_ff <= req_chan.is_empty;
      end
      rsp_status_ff <= rsp_status_in;
   end

   // checks
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_vld_ff |-> req_chan.ready)
      else $error("input register empty but item refused");

   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !$past(rsp_vld_ff)) |-> $past(s1_vld_ff && s1_last_ff))
      else $error("result raised without a final item");

   a_error_sticks: assert property (@(posedge clock) disable iff (reset)
      (err_ff != dirc_pkg::STATUS_VALID && s1_adv && !s1_last_ff) |=> (err_ff == $past(err_ff)))
      else $error("error code changed inside a string");

   a_acc_bounded: assert property (@(posedge clock) disable iff (reset)
      acc_ff <= {1'b1, {(dirc_pkg::ACC_W-1){1'b0}}})
      else $error("accumulator beyond largest magnitude");

   a_no_digit_no_value: assert property (@(posedge clock) disable iff (reset)
      !seen_ff |-> (acc_ff == '0))
      else $error("accumulator nonzero before any digit");

endmodule

/* sim/decimal_integer_range_checker_tb.sv */
// self-checking testbench for the decimal integer range checker
`timescale 1ns / 1ps

module decimal_integer_range_checker_tb;

   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 1000;
   localparam int END_LIMIT     = 20000;
   localparam int PHASE_CHARS   = 65;
   localparam int PHASES        = 8;
   localparam logic [dirc_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

   typedef struct {
      logic [dirc_pkg::CHAR_W-1:0] code;
      logic                        last;
      logic                        empty;
   } char_item_type;

   typedef enum {TAKE_ALL, TAKE_ALTERNATE, TAKE_RANDOM, TAKE_SPARSE} take_mode_type;

   logic clock = 1'b0;
   logic reset;
   logic                          csr_psel;
   logic                          csr_penable;
   logic                          csr_pwrite;
   logic [dirc_pkg::CSR_AW-1:0]   csr_paddr;
   logic [dirc_pkg::CSR_DW-1:0]   csr_pwdata;
   logic [dirc_pkg::CSR_DW-1:0]   csr_prdata;
   logic                          csr_pready;

   dirc_req_if req_bus ();
   dirc_rsp_if rsp_bus ();

   decimal_integer_range_checker u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   char_item_type                 char_queue[$];
   dirc_pkg::status_type          status_expect[$];
   logic [dirc_pkg::CHAR_W-1:0]   spell[$];

   // scanner state mirrored from the block
   logic [dirc_pkg::KIND_W-1:0]   kind_sel;
   logic [dirc_pkg::ACC_W-1:0]    scan_acc;
   logic                          scan_neg;
   logic                          scan_first;
   logic                          scan_seen;
   dirc_pkg::status_type          scan_err;

   int chars_planned = 0;
   int chars_taken = 0;
   int statuses_seen = 0;
   int settings_used = 0;
   int mismatches = 0;
   int quiet_cycles = 0;
   int status_tally[3] = '{0, 0, 0};

   function automatic logic [dirc_pkg::ACC_W-1:0] kind_cap(
      input logic [dirc_pkg::KIND_W-1:0] kind);
      case (kind)
         dirc_pkg::KIND_S64: return dirc_pkg::MAX_S64;
         dirc_pkg::KIND_U32: return dirc_pkg::MAX_U32;
         default:            return dirc_pkg::MAX_S32;
      endcase
   endfunction

   function automatic void clear_scan();
      scan_acc   = '0;
      scan_neg   = 1'b0;
      scan_first = 1'b1;
      scan_seen  = 1'b0;
      scan_err   = dirc_pkg::STATUS_VALID;
   endfunction

   // advances the scanner by one item, returns 1 when the item ends a string
   function automatic bit scan_char(input char_item_type it,
                                    output dirc_pkg::status_type verdict);
      logic [dirc_pkg::ACC_W-1:0] cap;
      logic [dirc_pkg::ACC_W-1:0] lim;
      logic [dirc_pkg::ACC_W-1:0] digit;
      bit                         signed_kind;
      signed_kind = (kind_sel != dirc_pkg::KIND_U32);
      cap = kind_cap(kind_sel);
      verdict = dirc_pkg::STATUS_VALID;
      if (!it.empty) begin
         if (scan_err != dirc_pkg::STATUS_VALID) begin
            scan_first = 1'b0;
         end else if (scan_first && signed_kind &&
                      (it.code == dirc_pkg::CHAR_MINUS || it.code == dirc_pkg::CHAR_PLUS)) begin
            scan_neg   = (it.code == dirc_pkg::CHAR_MINUS);
            scan_first = 1'b0;
         end else begin
            scan_first = 1'b0;
            if (it.code < dirc_pkg::CHAR_ZERO || it.code > dirc_pkg::CHAR_NINE) begin
               scan_err = dirc_pkg::STATUS_BAD_FORMAT;
            end else begin
               digit = {{(dirc_pkg::ACC_W-dirc_pkg::CHAR_W){1'b0}},
                        it.code - dirc_pkg::CHAR_ZERO};
               lim = cap + ((signed_kind && scan_neg) ? 64'd1 : 64'd0);
               if (scan_acc > cap / 64'd10) begin
                  scan_err = dirc_pkg::STATUS_OUT_OF_RANGE;
               end else if (scan_acc * 64'd10 + digit > lim) begin
                  scan_err = dirc_pkg::STATUS_OUT_OF_RANGE;
               end else begin
                  scan_acc  = scan_acc * 64'd10 + digit;
                  scan_seen = 1'b1;
               end
            end
         end
      end
      if (!it.last) return 1'b0;
      if (scan_err != dirc_pkg::STATUS_VALID) verdict = scan_err;
      else if (!scan_seen) verdict = dirc_pkg::STATUS_BAD_FORMAT;
      else verdict = dirc_pkg::STATUS_VALID;
      clear_scan();
      return 1'b1;
   endfunction

   task automatic log_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch %0d: %s", mismatches, msg);
   endtask

   task automatic add_item(input logic [dirc_pkg::CHAR_W-1:0] code, input bit last,
                           input bit empty);
      char_item_type it;
      it.code  = code;
      it.last  = last;
      it.empty = empty;
      char_queue.push_back(it);
      chars_planned++;
   endtask

   // one string: mostly well-formed numbers, many near the type limits, some broken or noise
   task automatic add_random_string(input logic [dirc_pkg::KIND_W-1:0] kind, input bit close);
      int                          shape;
      int                          sign_pick;
      bit                          neg;
      bit                          extra;
      bit                          trail_empty;
      logic [dirc_pkg::ACC_W-1:0]  mag;
      string                       text;
      spell.delete();
      shape = $urandom_range(0, 19);
      if (shape < 15) begin
         sign_pick = $urandom_range(0, (kind == dirc_pkg::KIND_U32) ? 9 : 2);
         neg = (sign_pick == 2) && (kind != dirc_pkg::KIND_U32);
         extra = 1'b0;
         case ($urandom_range(0, 3))
            0: mag = 64'($urandom_range(0, 999));
            1: mag = {$urandom, $urandom} >> $urandom_range(0, 63);
            2: mag = kind_cap(kind) + 64'(neg) + 64'($urandom_range(0, 6)) - 64'd3;
            default: begin
               mag = kind_cap(kind) / 64'd10 + 64'($urandom_range(0, 2)) - 64'd1;
               extra = 1'b1;
            end
         endcase
         if (sign_pick == 1) spell.push_back(dirc_pkg::CHAR_PLUS);
         if (sign_pick == 2) spell.push_back(dirc_pkg::CHAR_MINUS);
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 2)) spell.push_back(dirc_pkg::CHAR_ZERO);
         end
         text = $sformatf("%0d", mag);
         for (int i = 0; i < text.len(); i++) spell.push_back(text[i]);
         if (extra) spell.push_back(dirc_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
         // broken: a stray byte or sign dropped somewhere into the number
         if (shape >= 12) begin
            case ($urandom_range(0, 2))
               0: spell.insert($urandom_range(0, spell.size()), dirc_pkg::CHAR_MINUS);
               1: spell.insert($urandom_range(0, spell.size()), dirc_pkg::CHAR_PLUS);
               default: spell.insert($urandom_range(0, spell.size()), 8'($urandom));
            endcase
         end
      end else if (shape < 18) begin
         repeat ($urandom_range(1, 5)) spell.push_back(8'($urandom));
      end else if (shape == 18) begin
         spell.push_back(($urandom_range(0, 1) != 0) ? dirc_pkg::CHAR_MINUS
                                                     : dirc_pkg::CHAR_PLUS);
      end
      trail_empty = close && (spell.size() == 0 || $urandom_range(0, 9) == 0);
      foreach (spell[i]) begin
         if ($urandom_range(0, 11) == 0) add_item(8'($urandom), 1'b0, 1'b1);
         add_item(spell[i], close && !trail_empty && (i == spell.size() - 1), 1'b0);
      end
      if (trail_empty) add_item(8'($urandom), 1'b1, 1'b1);
   endtask

   // block is idle once all items are in, all statuses are out, and the pipe has emptied
   task automatic settle();
      while (char_queue.size() != 0 || req_bus.valid || status_expect.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_int_kind(input logic [dirc_pkg::KIND_W-1:0] kind);
      logic [dirc_pkg::CSR_DW-1:0] wdata;
      logic [dirc_pkg::CSR_DW-1:0] rdata;
      wdata = ($urandom_range(0, 1) != 0) ? $urandom : '0;
      wdata[dirc_pkg::KIND_W-1:0] = kind;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= dirc_pkg::CSR_ADDR_KIND;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      kind_sel = kind;
      settings_used++;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (rdata !== {{(dirc_pkg::CSR_DW-dirc_pkg::KIND_W){1'b0}}, kind})
         log_mismatch($sformatf("int_kind readback expected %0h got %0h", kind, rdata));
      @(negedge clock);
   endtask

   // sender: bursts of items with random gaps between them
   int burst_left;
   int gap_left;

   always @(posedge clock) begin : char_driver
      char_item_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left = $urandom_range(1, 24);
         gap_left = 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (char_queue.size() != 0) begin
            nxt = char_queue.pop_front();
            req_bus.valid     <= 1'b1;
            req_bus.char_code <= nxt.code;
            req_bus.is_last   <= nxt.last;
            req_bus.is_empty  <= nxt.empty;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // predict on every accepted item
   always @(posedge clock) begin : char_tracker
      char_item_type        got;
      dirc_pkg::status_type verdict;
      if (!reset && req_bus.valid && req_bus.ready) begin
         got.code  = req_bus.char_code;
         got.last  = req_bus.is_last;
         got.empty = req_bus.is_empty;
         chars_taken++;
         if (scan_char(got, verdict)) status_expect.push_back(verdict);
      end
   end

   // receiver stall pattern, with the mode picked at random among four
   int            stall_tick = 0;
   take_mode_type take_mode = TAKE_ALL;

   always @(posedge clock) begin : status_stall
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         stall_tick++;
         if (stall_tick % 40 == 0) take_mode = take_mode_type'($urandom_range(0, 3));
         case (take_mode)
            TAKE_ALL:       rsp_bus.ready <= 1'b1;
            TAKE_ALTERNATE: rsp_bus.ready <= (stall_tick % 2 == 0);
            TAKE_RANDOM:    rsp_bus.ready <= ($urandom_range(0, 1) != 0);
            default:        rsp_bus.ready <= (stall_tick % 4 == 0);
         endcase
      end
   end

   always @(posedge clock) begin : status_monitor
      dirc_pkg::status_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         statuses_seen++;
         if (rsp_bus.status <= dirc_pkg::STATUS_OUT_OF_RANGE)
            status_tally[rsp_bus.status]++;
         if (status_expect.size() == 0) begin
            log_mismatch($sformatf("status %0h with none expected", rsp_bus.status));
         end else begin
            want = status_expect.pop_front();
            if (rsp_bus.status !== want)
               log_mismatch($sformatf("status %0d expected %0h got %0h",
                                      statuses_seen, want, rsp_bus.status));
         end
      end
   end

   always @(posedge clock) begin : quiet_count
      if (reset || csr_psel || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(negedge clock);
      $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      logic [dirc_pkg::KIND_W-1:0] kind;
      int                          phase_first;
      int                          waited;
      reset = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.char_code = '0;
      req_bus.is_last   = 1'b0;
      req_bus.is_empty  = 1'b0;
      rsp_bus.ready     = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      kind_sel = dirc_pkg::KIND_S32;
      clear_scan();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed cases under the reset type
      add_item(8'h00, 1'b1, 1'b1);                                   // empty string
      add_item(dirc_pkg::CHAR_MINUS, 1'b1, 1'b0);                    // sign only
      add_item(dirc_pkg::CHAR_PLUS, 1'b0, 1'b0);
      add_item(dirc_pkg::CHAR_ZERO + 8'd7, 1'b1, 1'b0);
      add_item(dirc_pkg::CHAR_ZERO + 8'd1, 1'b0, 1'b0);              // late sign
      add_item(dirc_pkg::CHAR_MINUS, 1'b1, 1'b0);
      add_item(dirc_pkg::CHAR_ZERO - 8'd1, 1'b0, 1'b0);              // first error sticks
      add_item(dirc_pkg::CHAR_NINE, 1'b0, 1'b0);
      add_item(dirc_pkg::CHAR_NINE + 8'd1, 1'b1, 1'b0);
      add_item(8'hff, 1'b0, 1'b1);                                   // empty items around a digit
      add_item(dirc_pkg::CHAR_ZERO, 1'b0, 1'b0);
      add_item(8'h00, 1'b1, 1'b1);
      add_item(8'hff, 1'b1, 1'b0);
      add_item(8'h00, 1'b1, 1'b0);
      add_item(dirc_pkg::CHAR_MINUS, 1'b0, 1'b0);                    // type change mid string
      settle();
      set_int_kind(dirc_pkg::KIND_U32);
      add_item(dirc_pkg::CHAR_ZERO + 8'd5, 1'b1, 1'b0);
      add_item(dirc_pkg::CHAR_PLUS, 1'b0, 1'b0);                     // sign in unsigned
      add_item(dirc_pkg::CHAR_ZERO + 8'd1, 1'b1, 1'b0);
      settle();
      set_int_kind(KIND_SPARE);
      add_item(dirc_pkg::CHAR_MINUS, 1'b0, 1'b0);
      add_item(dirc_pkg::CHAR_NINE, 1'b1, 1'b0);
      settle();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: kind = dirc_pkg::KIND_S32;
            1: kind = dirc_pkg::KIND_S64;
            2: kind = dirc_pkg::KIND_U32;
            3: kind = KIND_SPARE;
            default: kind = 2'($urandom_range(0, 3));
         endcase
         set_int_kind(kind);
         phase_first = chars_planned;
         while (chars_planned - phase_first < PHASE_CHARS) add_random_string(kind, 1'b1);
         // leave a string open across the next type change now and then
         if ($urandom_range(0, 2) == 0) add_random_string(kind, 1'b0);
         if (ph < PHASES - 1) settle();
      end

      for (waited = 0; waited < END_LIMIT && (char_queue.size() != 0 || req_bus.valid ||
           status_expect.size() != 0); waited++)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (status_expect.size() != 0) begin
         $display("%0d expected statuses never arrived", status_expect.size());
         mismatches += status_expect.size();
      end

      $display("run: %0d character items, %0d statuses checked, %0d int_kind writes",
               chars_taken, statuses_seen, settings_used);
      $display("statuses: %0d valid, %0d bad format, %0d out of range",
               status_tally[dirc_pkg::STATUS_VALID], status_tally[dirc_pkg::STATUS_BAD_FORMAT],
               status_tally[dirc_pkg::STATUS_OUT_OF_RANGE]);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* decimal_integer_range_checker.f */
sv/dirc_pkg.sv
sv/dirc_if.sv
sv/decimal_integer_range_checker.sv
sim/decimal_integer_range_checker_tb.sv
